// ===== design/poi_pkg.sv =====
package poi_pkg;

    localparam int CountW    = 16;
    localparam int GainW     = 24;
    localparam int YawW      = 16;
    localparam int PosW      = 48;
    localparam int SmoothW   = 40;
    localparam int UnwW      = 32;
    localparam int TurnW     = 16;
    localparam int IndexW    = 2;
    localparam int OpW       = 2;
    localparam int MulAW     = 40;
    localparam int MulBW     = 24;
    localparam int ProdW     = MulAW + MulBW;
    localparam int RotW      = 57;
    localparam int RotShift  = 23;
    localparam int StepW     = RotW - RotShift;
    localparam int CordW     = 18;
    localparam int AngW      = 24;
    localparam int CordSteps = 16;
    localparam int IterW     = 4;

    localparam logic [OpW-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OpW-1:0] OP_SET     = 2'd1;
    localparam logic [OpW-1:0] OP_RESTART = 2'd2;

    localparam logic [IndexW-1:0] REG_SWAP_AXES = 2'd0;
    localparam logic [IndexW-1:0] REG_GAIN_X    = 2'd1;
    localparam logic [IndexW-1:0] REG_GAIN_Y    = 2'd2;

    localparam logic signed [GainW-1:0] GAIN_X_RESET = 24'sd17252;
    localparam logic signed [GainW-1:0] GAIN_Y_RESET = 24'sd16668;

    localparam logic signed [CountW-1:0] COUNT_BAD  = 16'sh8000;
    localparam logic [YawW:0]            JUMP_LIMIT = 17'd2000;
    localparam logic [YawW:0]            WRAP_LOW   = 17'd34000;
    localparam logic [YawW:0]            WRAP_HIGH  = 17'd38000;
    localparam logic signed [YawW+1:0]   HALF_TURN  = 18'sd18000;
    localparam logic signed [YawW+1:0]   FULL_TURN  = 18'sd36000;
    localparam logic signed [YawW+1:0]   QUART_TURN = 18'sd9000;
    localparam logic signed [YawW-1:0]   SEAM_LIMIT = 16'sd15000;
    localparam logic signed [TurnW-1:0]  TURN_MAX   = 16'sd32767;
    localparam logic signed [CordW-1:0]  CORD_START = 18'sd19898;
    localparam logic signed [CordW-1:0]  TRIG_MAX   = 18'sd32767;
    localparam logic signed [RotW-1:0]   ROUND_HALF = 57'sd4194304;
    localparam logic signed [UnwW-1:0]   TURN_UNITS = 32'sd36000;

    typedef logic signed [CountW-1:0]  count_t;
    typedef logic signed [GainW-1:0]   gain_t;
    typedef logic signed [YawW-1:0]    yaw_t;
    typedef logic signed [PosW-1:0]    pos_t;
    typedef logic signed [UnwW-1:0]    unw_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_GAIN_X,
        ST_GAIN_Y,
        ST_SMOOTH_Y,
        ST_CORDIC,
        ST_CLAMP,
        ST_ROT_XC,
        ST_ROT_YS,
        ST_ROT_XS,
        ST_ROT_YC,
        ST_ROT_END,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    function automatic logic signed [AngW-1:0] atan_lut(input logic [IterW-1:0] i);
        logic signed [AngW-1:0] v;
        begin
            case (i)
                4'd0:    v = 24'sd1152000;
                4'd1:    v = 24'sd680065;
                4'd2:    v = 24'sd359328;
                4'd3:    v = 24'sd182400;
                4'd4:    v = 24'sd91554;
                4'd5:    v = 24'sd45822;
                4'd6:    v = 24'sd22916;
                4'd7:    v = 24'sd11459;
                4'd8:    v = 24'sd5730;
                4'd9:    v = 24'sd2865;
                4'd10:   v = 24'sd1432;
                4'd11:   v = 24'sd716;
                4'd12:   v = 24'sd358;
                4'd13:   v = 24'sd179;
                4'd14:   v = 24'sd90;
                default: v = 24'sd45;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== design/poi_if.sv =====
interface poi_in_if;
    import poi_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OpW-1:0]       operation;
    count_t               count_x;
    count_t               count_y;
    yaw_t                 yaw_sample;
    pos_t                 load_x;
    pos_t                 load_y;
    modport source (output valid, operation, count_x, count_y, yaw_sample, load_x, load_y,
                    input ready);
    modport sink   (input valid, operation, count_x, count_y, yaw_sample, load_x, load_y,
                    output ready);
endinterface

interface poi_out_if;
    import poi_pkg::*;
    logic   valid;
    logic   ready;
    pos_t   pos_x;
    pos_t   pos_y;
    yaw_t   heading;
    unw_t   unwrapped_heading;
    logic   motion_ok;
    logic   yaw_ok;
    modport source (output valid, pos_x, pos_y, heading, unwrapped_heading, motion_ok, yaw_ok,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, heading, unwrapped_heading, motion_ok, yaw_ok,
                    output ready);
endinterface

interface poi_cfg_if;
    import poi_pkg::*;
    logic                valid;
    logic                ready;
    logic [IndexW-1:0]   reg_index;
    logic [GainW-1:0]    data;
    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

// ===== design/planar_odometry_integrator.sv =====
// Channel  Direction  Payload
// cfg      in         reg_index, data (swap_axes, gain_x, gain_y)
// sample   in         operation, count_x, count_y, yaw_sample, load_x, load_y
// result   out        pos_x, pos_y, heading, unwrapped_heading, motion_ok, yaw_ok
//
// A sample item passes through one shared 40x24 multiplier (six products) and a
// 16-step CORDIC iterated one step a cycle. Set position, restart and unknown
// operations go straight from idle to emit. cfg is always ready.
// sample.ready is high only in idle; a result held in the output register does not block it.
// Reset loads default gains and clears the FSM, yaw, filters, position, turns, out valid.
module planar_odometry_integrator (
    input  logic     clk,
    input  logic     rst_n,
    poi_cfg_if.sink  cfg,
    poi_in_if.sink   sample,
    poi_out_if.source result
);
    import poi_pkg::*;

    state_t                    state_reg, state_next;
    logic [OpW-1:0]            op_reg, op_next;
    count_t                    cx_reg, cx_next, cy_reg, cy_next;
    yaw_t                      yaw_reg, yaw_next;
    logic                      swap_reg, swap_next;
    gain_t                     gain_x_reg, gain_x_next, gain_y_reg, gain_y_next;
    yaw_t                      last_yaw_reg, last_yaw_next;
    logic signed [SmoothW-1:0] smooth_x_reg, smooth_x_next, smooth_y_reg, smooth_y_next;
    pos_t                      acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic signed [TurnW-1:0]   turn_reg, turn_next;
    logic                      mok_reg, mok_next, yok_reg, yok_next;
    logic signed [ProdW-1:0]   prod_reg, prod_next;
    logic signed [RotW-1:0]    rsum_reg, rsum_next;
    logic signed [StepW-1:0]   gx_reg, gx_next;
    logic signed [CordW-1:0]   cord_x_reg, cord_x_next, cord_y_reg, cord_y_next;
    logic signed [AngW-1:0]    z_reg, z_next;
    logic                      neg_reg, neg_next;
    logic [IterW-1:0]          iter_reg, iter_next;
    yaw_t                      cs_reg, cs_next, sn_reg, sn_next;
    logic                      ovalid_reg, ovalid_next;
    pos_t                      opx_reg, opx_next, opy_reg, opy_next;
    yaw_t                      ohead_reg, ohead_next;
    unw_t                      ounw_reg, ounw_next;
    logic                      omok_reg, omok_next, oyok_reg, oyok_next;

    logic signed [MulAW-1:0]   mul_a;
    logic signed [MulBW-1:0]   mul_b;
    logic signed [ProdW-1:0]   mul_p;
    logic signed [YawW:0]      yaw_d;
    logic [YawW:0]             yaw_ad;
    logic                      jump;
    logic signed [YawW+1:0]    ang_a, ang_b;
    logic                      ang_neg;
    logic signed [CordW-1:0]   x_sh, y_sh, x_fin, y_fin;
    logic signed [SmoothW:0]   sum_s;
    logic signed [RotW-1:0]    rot_t;
    logic signed [UnwW-1:0]    unw;

    assign mul_p = mul_a * mul_b;

    function automatic yaw_t clamp15(input logic signed [CordW-1:0] v);
        yaw_t r;
        begin
            if (v > TRIG_MAX)
                r = YawW'(TRIG_MAX);
            else if (v < -TRIG_MAX)
                r = YawW'(-TRIG_MAX);
            else
                r = YawW'(v);
            return r;
        end
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        yaw_next      = yaw_reg;
        swap_next     = swap_reg;
        gain_x_next   = gain_x_reg;
        gain_y_next   = gain_y_reg;
        last_yaw_next = last_yaw_reg;
        smooth_x_next = smooth_x_reg;
        smooth_y_next = smooth_y_reg;
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;
        turn_next     = turn_reg;
        mok_next      = mok_reg;
        yok_next      = yok_reg;
        prod_next     = prod_reg;
        rsum_next     = rsum_reg;
        gx_next       = gx_reg;
        cord_x_next   = cord_x_reg;
        cord_y_next   = cord_y_reg;
        z_next        = z_reg;
        neg_next      = neg_reg;
        iter_next     = iter_reg;
        cs_next       = cs_reg;
        sn_next       = sn_reg;
        ovalid_next   = ovalid_reg & ~result.ready;
        opx_next      = opx_reg;
        opy_next      = opy_reg;
        ohead_next    = ohead_reg;
        ounw_next     = ounw_reg;
        omok_next     = omok_reg;
        oyok_next     = oyok_reg;

        mul_a   = '0;
        mul_b   = '0;
        yaw_d   = (YawW+1)'(yaw_reg) - (YawW+1)'(last_yaw_reg);
        yaw_ad  = yaw_d[YawW] ? (YawW+1)'(-yaw_d) : yaw_d;
        jump    = (yaw_ad > JUMP_LIMIT) && ((yaw_ad < WRAP_LOW) || (yaw_ad > WRAP_HIGH));
        ang_a   = (YawW+2)'(yaw_reg);
        if (ang_a >= HALF_TURN)
            ang_a = ang_a - FULL_TURN;
        else if (ang_a < -HALF_TURN)
            ang_a = ang_a + FULL_TURN;
        ang_b   = ang_a;
        ang_neg = 1'b0;
        if (ang_a > QUART_TURN)
        begin
            ang_b   = ang_a - HALF_TURN;
            ang_neg = 1'b1;
        end
        else if (ang_a < -QUART_TURN)
        begin
            ang_b   = ang_a + HALF_TURN;
            ang_neg = 1'b1;
        end
        x_sh  = cord_x_reg >>> iter_reg;
        y_sh  = cord_y_reg >>> iter_reg;
        x_fin = neg_reg ? -cord_x_reg : cord_x_reg;
        y_fin = neg_reg ? -cord_y_reg : cord_y_reg;
        sum_s = '0;
        rot_t = '0;
        unw   = UnwW'(last_yaw_reg) + UnwW'(turn_reg) * TURN_UNITS;

        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_SWAP_AXES: swap_next   = cfg.data[0];
                REG_GAIN_X:    gain_x_next = cfg.data;
                REG_GAIN_Y:    gain_y_next = cfg.data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    op_next  = sample.operation;
                    cx_next  = sample.count_x;
                    cy_next  = sample.count_y;
                    yaw_next = sample.yaw_sample;
                    mok_next = 1'b0;
                    yok_next = 1'b0;
                    state_next = ST_EMIT;
                    unique case (sample.operation)
                        OP_SAMPLE:  state_next = ST_PREP;
                        OP_SET:
                        begin
                            acc_x_next = sample.load_x;
                            acc_y_next = sample.load_y;
                        end
                        OP_RESTART:
                        begin
                            last_yaw_next = '0;
                            smooth_x_next = '0;
                            smooth_y_next = '0;
                            acc_x_next    = '0;
                            acc_y_next    = '0;
                            turn_next     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP:
            begin
                mok_next = (cx_reg != COUNT_BAD) && (cy_reg != COUNT_BAD);
                if (!mok_next)
                begin
                    cx_next = '0;
                    cy_next = '0;
                end
                yok_next = ~jump;
                if (jump)
                    yaw_next = last_yaw_reg;
                state_next = ST_GAIN_X;
            end
            ST_GAIN_X:
            begin
                mul_a       = MulAW'(swap_reg ? cy_reg : cx_reg);
                mul_b       = gain_x_reg;
                prod_next   = mul_p;
                z_next      = {(AngW-8)'(ang_b), 8'd0};
                neg_next    = ang_neg;
                cord_x_next = CORD_START;
                cord_y_next = '0;
                iter_next   = '0;
                state_next  = ST_GAIN_Y;
            end
            ST_GAIN_Y:
            begin
                sum_s         = (SmoothW+1)'(smooth_x_reg)
                              + (SmoothW+1)'($signed(prod_reg[SmoothW-1:0]));
                smooth_x_next = sum_s[SmoothW:1];
                mul_a         = MulAW'(swap_reg ? cx_reg : cy_reg);
                mul_b         = gain_y_reg;
                prod_next     = mul_p;
                state_next    = ST_SMOOTH_Y;
            end
            ST_SMOOTH_Y:
            begin
                sum_s         = (SmoothW+1)'(smooth_y_reg)
                              + (SmoothW+1)'($signed(prod_reg[SmoothW-1:0]));
                smooth_y_next = sum_s[SmoothW:1];
                state_next    = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (!z_reg[AngW-1])
                begin
                    cord_x_next = cord_x_reg - y_sh;
                    cord_y_next = cord_y_reg + x_sh;
                    z_next      = z_reg - atan_lut(iter_reg);
                end
                else
                begin
                    cord_x_next = cord_x_reg + y_sh;
                    cord_y_next = cord_y_reg - x_sh;
                    z_next      = z_reg + atan_lut(iter_reg);
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == IterW'(CordSteps - 1))
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cs_next    = clamp15(x_fin);
                sn_next    = clamp15(y_fin);
                state_next = ST_ROT_XC;
            end
            ST_ROT_XC:
            begin
                mul_a      = smooth_x_reg;
                mul_b      = MulBW'(cs_reg);
                prod_next  = mul_p;
                state_next = ST_ROT_YS;
            end
            ST_ROT_YS:
            begin
                rsum_next  = prod_reg[RotW-1:0] + ROUND_HALF;
                mul_a      = smooth_y_reg;
                mul_b      = MulBW'(sn_reg);
                prod_next  = mul_p;
                state_next = ST_ROT_XS;
            end
            ST_ROT_XS:
            begin
                rot_t      = rsum_reg - prod_reg[RotW-1:0];
                gx_next    = rot_t[RotW-1:RotShift];
                mul_a      = smooth_x_reg;
                mul_b      = MulBW'(sn_reg);
                prod_next  = mul_p;
                state_next = ST_ROT_YC;
            end
            ST_ROT_YC:
            begin
                rsum_next  = prod_reg[RotW-1:0] + ROUND_HALF;
                mul_a      = smooth_y_reg;
                mul_b      = MulBW'(cs_reg);
                prod_next  = mul_p;
                state_next = ST_ROT_END;
            end
            ST_ROT_END:
            begin
                rot_t      = rsum_reg + prod_reg[RotW-1:0];
                if (mok_reg && yok_reg)
                begin
                    acc_x_next = acc_x_reg + PosW'(gx_reg);
                    acc_y_next = acc_y_reg + PosW'($signed(rot_t[RotW-1:RotShift]));
                end
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if ((last_yaw_reg > SEAM_LIMIT) && (yaw_reg < -SEAM_LIMIT))
                begin
                    if (turn_reg < TURN_MAX)
                        turn_next = turn_reg + 1'b1;
                end
                else if ((last_yaw_reg < -SEAM_LIMIT) && (yaw_reg > SEAM_LIMIT))
                begin
                    if (turn_reg > -TURN_MAX)
                        turn_next = turn_reg - 1'b1;
                end
                last_yaw_next = yaw_reg;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    opx_next    = acc_x_reg;
                    opy_next    = acc_y_reg;
                    ohead_next  = last_yaw_reg;
                    ounw_next   = unw;
                    omok_next   = mok_reg;
                    oyok_next   = yok_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            swap_reg     <= 1'b0;
            gain_x_reg   <= GAIN_X_RESET;
            gain_y_reg   <= GAIN_Y_RESET;
            last_yaw_reg <= '0;
            smooth_x_reg <= '0;
            smooth_y_reg <= '0;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            turn_reg     <= '0;
            mok_reg      <= 1'b0;
            yok_reg      <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            swap_reg     <= swap_next;
            gain_x_reg   <= gain_x_next;
            gain_y_reg   <= gain_y_next;
            last_yaw_reg <= last_yaw_next;
            smooth_x_reg <= smooth_x_next;
            smooth_y_reg <= smooth_y_next;
            acc_x_reg    <= acc_x_next;
            acc_y_reg    <= acc_y_next;
            turn_reg     <= turn_next;
            mok_reg      <= mok_next;
            yok_reg      <= yok_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        yaw_reg    <= yaw_next;
        prod_reg   <= prod_next;
        rsum_reg   <= rsum_next;
        gx_reg     <= gx_next;
        cord_x_reg <= cord_x_next;
        cord_y_reg <= cord_y_next;
        z_reg      <= z_next;
        neg_reg    <= neg_next;
        iter_reg   <= iter_next;
        cs_reg     <= cs_next;
        sn_reg     <= sn_next;
        opx_reg    <= opx_next;
        opy_reg    <= opy_next;
        ohead_reg  <= ohead_next;
        ounw_reg   <= ounw_next;
        omok_reg   <= omok_next;
        oyok_reg   <= oyok_next;
    end

    assign sample.ready             = (state_reg == ST_IDLE);
    assign cfg.ready                = 1'b1;
    assign result.valid             = ovalid_reg;
    assign result.pos_x             = opx_reg;
    assign result.pos_y             = opy_reg;
    assign result.heading           = ohead_reg;
    assign result.unwrapped_heading = ounw_reg;
    assign result.motion_ok         = omok_reg;
    assign result.yaw_ok            = oyok_reg;

    a_turn_sat: assert property (@(posedge clk) disable iff (!rst_n)
        turn_reg != 16'sh8000)
        else $error("turn count left its range");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT_END) && !(mok_reg && yok_reg)
        |=> $stable(acc_x_reg) && $stable(acc_y_reg))
        else $error("position moved on a rejected step");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && (!result.valid || result.ready) |=> result.valid)
        else $error("result lost on emit");

    a_op_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |-> (op_reg == OP_SAMPLE))
        else $error("non-sample item entered the sample path");

endmodule

// ===== dv/planar_odometry_integrator_tb.sv =====
`timescale 1ns / 1ps

module planar_odometry_integrator_tb;
    import poi_pkg::*;

    localparam logic [OpW-1:0] OP_IGNORED = 2'd3;
    localparam int CycleLimit = 1000000;
    localparam int DrainCycles = 40;

    typedef struct {
        pos_t pos_x;
        pos_t pos_y;
        yaw_t heading;
        unw_t unwrapped_heading;
        logic motion_ok;
        logic yaw_ok;
    } pose_t;

    localparam longint ArcTab [16] = '{1152000, 680065, 359328, 182400, 91554, 45822,
                                       22916, 11459, 5730, 2865, 1432, 716, 358, 179,
                                       90, 45};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int unsigned cycles = 0;
    int failures = 0;

    poi_cfg_if cfg ();
    poi_in_if  sample ();
    poi_out_if result ();

    planar_odometry_integrator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .sample (sample.sink),
        .result (result.source)
    );

    // shadow of the block's registers and state
    logic                 swap_q;
    gain_t                gain_x_q;
    gain_t                gain_y_q;
    yaw_t                 last_yaw_q;
    logic signed [39:0]   smooth_x_q;
    logic signed [39:0]   smooth_y_q;
    pos_t                 acc_x_q;
    pos_t                 acc_y_q;
    logic signed [15:0]   turns_q;
    pose_t                pending_poses[$];

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("[planar_odometry_integrator] ERROR");
            $finish;
        end
    end

    task automatic sin_cos(input longint ang, output longint sn, output longint cs);
        longint x;
        longint y;
        longint z;
        longint nx;
        bit neg;
        x = 19898;
        y = 0;
        neg = 0;
        if (ang >= 18000) ang -= 36000;
        else if (ang < -18000) ang += 36000;
        if (ang > 9000)
        begin
            ang -= 18000;
            neg = 1;
        end
        else if (ang < -9000)
        begin
            ang += 18000;
            neg = 1;
        end
        z = ang * 256;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ArcTab[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ArcTab[i];
            end
            x = nx;
        end
        if (neg)
        begin
            x = -x;
            y = -y;
        end
        cs = (x > 32767) ? 32767 : (x < -32767) ? -32767 : x;
        sn = (y > 32767) ? 32767 : (y < -32767) ? -32767 : y;
    endtask

    function automatic pose_t snapshot(input logic mok, input logic yok);
        pose_t p;
        longint unw;
        unw = longint'(last_yaw_q) + longint'(turns_q) * 36000;
        p.pos_x = acc_x_q;
        p.pos_y = acc_y_q;
        p.heading = last_yaw_q;
        p.unwrapped_heading = unw_t'(unw);
        p.motion_ok = mok;
        p.yaw_ok = yok;
        return p;
    endfunction

    task automatic advance_pose(input logic [OpW-1:0] op, input count_t cx_in,
                                input count_t cy_in, input yaw_t yaw_in,
                                input pos_t lx, input pos_t ly);
        longint cx;
        longint cy;
        longint yaw;
        longint d;
        longint ad;
        longint t;
        longint sn;
        longint cs;
        longint gx;
        longint gy;
        longint sx;
        longint sy;
        logic mok;
        logic yok;
        mok = 1'b1;
        yok = 1'b1;
        cx = cx_in;
        cy = cy_in;
        yaw = yaw_in;
        if (op == OP_SET)
        begin
            acc_x_q = lx;
            acc_y_q = ly;
            pending_poses.push_back(snapshot(1'b0, 1'b0));
        end
        else if (op == OP_RESTART)
        begin
            last_yaw_q = 0;
            smooth_x_q = 0;
            smooth_y_q = 0;
            acc_x_q = 0;
            acc_y_q = 0;
            turns_q = 0;
            pending_poses.push_back(snapshot(1'b0, 1'b0));
        end
        else if (op == OP_IGNORED)
        begin
            pending_poses.push_back(snapshot(1'b0, 1'b0));
        end
        else
        begin
            if (cx == -32768 || cy == -32768)
            begin
                mok = 1'b0;
                cx = 0;
                cy = 0;
            end
            d = yaw - last_yaw_q;
            ad = d < 0 ? -d : d;
            if (ad > 2000 && (ad - 36000 > 2000 || 36000 - ad > 2000))
            begin
                yok = 1'b0;
                yaw = last_yaw_q;
            end
            if (swap_q)
            begin
                t = cx;
                cx = cy;
                cy = t;
            end
            smooth_x_q = 40'((longint'(smooth_x_q) + cx * longint'(gain_x_q)) >>> 1);
            smooth_y_q = 40'((longint'(smooth_y_q) + cy * longint'(gain_y_q)) >>> 1);
            sx = smooth_x_q;
            sy = smooth_y_q;
            sin_cos(yaw, sn, cs);
            gx = (sx * cs - sy * sn + (64'sd1 <<< 22)) >>> 23;
            gy = (sx * sn + sy * cs + (64'sd1 <<< 22)) >>> 23;
            if (mok && yok)
            begin
                acc_x_q = acc_x_q + pos_t'(gx);
                acc_y_q = acc_y_q + pos_t'(gy);
            end
            if (last_yaw_q > 15000 && yaw < -15000)
            begin
                if (turns_q < 32767) turns_q++;
            end
            else if (last_yaw_q < -15000 && yaw > 15000)
            begin
                if (turns_q > -32767) turns_q--;
            end
            last_yaw_q = yaw_t'(yaw);
            pending_poses.push_back(snapshot(mok, yok));
        end
    endtask

    task automatic send_item(input logic [OpW-1:0] op, input count_t cx, input count_t cy,
                             input yaw_t yaw, input pos_t lx, input pos_t ly);
        while (pending_poses.size() != 0) @(posedge clk);
        sample.valid <= 1'b1;
        sample.operation <= op;
        sample.count_x <= cx;
        sample.count_y <= cy;
        sample.yaw_sample <= yaw;
        sample.load_x <= lx;
        sample.load_y <= ly;
        do @(posedge clk); while (!sample.ready);
        sample.valid <= 1'b0;
        advance_pose(op, cx, cy, yaw, lx, ly);
    endtask

    task automatic hold_off(input int n);
        sample.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic settle();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IndexW-1:0] idx, input logic [GainW-1:0] value);
        cfg.valid <= 1'b1;
        cfg.reg_index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_SWAP_AXES) swap_q = value[0];
        else if (idx == REG_GAIN_X) gain_x_q = value;
        else if (idx == REG_GAIN_Y) gain_y_q = value;
    endtask

    task automatic configure(input logic swap, input gain_t gx, input gain_t gy);
        settle();
        write_reg(REG_SWAP_AXES, {23'd0, swap});
        write_reg(REG_GAIN_X, gx);
        write_reg(REG_GAIN_Y, gy);
    endtask

    function automatic yaw_t next_yaw();
        int r;
        int y;
        r = $urandom_range(99);
        if (r < 70)
        begin
            y = int'(last_yaw_q) + $urandom_range(3998) - 1999;
            if (y > 18000) y -= 36000;
            if (y < -18000) y += 36000;
        end
        else if (r < 80)
            y = (last_yaw_q >= 0 ? -18000 : 18000) + (int'(last_yaw_q) % 2000);
        else if (r < 88)
            y = int'(last_yaw_q) + ($urandom_range(1) ? 1 : -1) * $urandom_range(2000, 2001);
        else if (r < 94)
            y = $urandom_range(36000) - 18000;
        else
            y = $urandom();
        return yaw_t'(y);
    endfunction

    function automatic count_t next_count();
        int r;
        r = $urandom_range(99);
        if (r < 4) return COUNT_BAD;
        if (r < 8) return 16'sd32767;
        if (r < 50) return count_t'($urandom_range(400) - 200);
        return count_t'($urandom());
    endfunction

    task automatic random_items(input int n);
        int burst;
        int r;
        logic [OpW-1:0] op;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(3) != 0) hold_off($urandom_range(0, 40));
            end
            burst--;
            r = $urandom_range(99);
            op = r < 90 ? OP_SAMPLE : r < 95 ? OP_SET : r < 98 ? OP_RESTART : OP_IGNORED;
            send_item(op, next_count(), next_count(), next_yaw(),
                      pos_t'({$urandom(), $urandom()}), pos_t'({$urandom(), $urandom()}));
        end
    endtask

    task automatic test_directed();
        send_item(OP_SAMPLE, 16'sd32767, 16'sd32767, 16'sd0, '0, '0);
        send_item(OP_SAMPLE, -16'sd32767, 16'sd100, 16'sd1500, '0, '0);
        send_item(OP_SAMPLE, COUNT_BAD, 16'sd5, 16'sd3000, '0, '0);
        send_item(OP_SAMPLE, 16'sd5, COUNT_BAD, 16'sd3500, '0, '0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd100, 16'sd9000, '0, '0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd100, 16'sd11000, '0, '0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd100, 16'sd13000, '0, '0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd100, 16'sd15000, '0, '0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd100, 16'sd17000, '0, '0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd100, 16'sd18000, '0, '0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd100, -16'sd17500, '0, '0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd100, -16'sd18000, '0, '0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd100, 16'sd17000, '0, '0);
        send_item(OP_SAMPLE, 16'sd1, 16'sd1, 16'sd0, '0, '0);
        send_item(OP_SAMPLE, 16'sd1, 16'sd1, 16'sd32767, '0, '0);
        send_item(OP_SAMPLE, 16'sd1, 16'sd1, -16'sd32768, '0, '0);
        send_item(OP_SET, 16'sd0, 16'sd0, 16'sd0, 48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000);
        send_item(OP_SAMPLE, 16'sd32767, -16'sd32767, 16'sd0, '0, '0);
        send_item(OP_SET, 16'sd0, 16'sd0, 16'sd0, 48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF);
        send_item(OP_SAMPLE, -16'sd32767, 16'sd32767, 16'sd0, '0, '0);
        send_item(OP_IGNORED, 16'sd7, 16'sd7, 16'sd7, 48'sd7, 48'sd7);
        send_item(OP_RESTART, 16'sd0, 16'sd0, 16'sd0, '0, '0);
    endtask

    task automatic test_default_gains();
        random_items(250);
    endtask

    task automatic test_swapped_extreme_gains();
        configure(1'b1, 24'sh7FFFFF, 24'sh800000);
        random_items(200);
    endtask

    task automatic test_inverted_extreme_gains();
        configure(1'b0, 24'sh800000, 24'sh7FFFFF);
        random_items(200);
    endtask

    task automatic test_zero_gain();
        configure(1'b1, 24'sd0, GAIN_Y_RESET);
        random_items(150);
    endtask

    task automatic test_random_gains();
        repeat (4)
        begin
            configure(1'($urandom()), gain_t'($urandom()), gain_t'($urandom()));
            random_items(100);
        end
    endtask

    // receiver: switch between always ready, coin flips and long stalls
    int ready_mode = 0;
    int ready_run = 0;
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (ready_run == 0)
            begin
                ready_mode <= $urandom_range(2);
                ready_run <= $urandom_range(50, 300);
            end
            else
            begin
                ready_run <= ready_run - 1;
            end
            if (ready_mode == 0)
                result.ready <= 1'b1;
            else if (ready_mode == 1)
                result.ready <= 1'($urandom());
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                result.ready <= 1'b0;
            end
            else
            begin
                stall_left <= $urandom_range(0, 25);
                result.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $display("%0t: unexpected result pos_x %0d", $time, result.pos_x);
                failures++;
            end
            else
            begin
                e = pending_poses.pop_front();
                if (result.pos_x !== e.pos_x)
                begin
                    $display("%0t: pos_x exp %0d got %0d", $time, e.pos_x, result.pos_x);
                    failures++;
                end
                if (result.pos_y !== e.pos_y)
                begin
                    $display("%0t: pos_y exp %0d got %0d", $time, e.pos_y, result.pos_y);
                    failures++;
                end
                if (result.heading !== e.heading)
                begin
                    $display("%0t: heading exp %0d got %0d", $time, e.heading,
                             result.heading);
                    failures++;
                end
                if (result.unwrapped_heading !== e.unwrapped_heading)
                begin
                    $display("%0t: unwrapped_heading exp %0d got %0d", $time,
                             e.unwrapped_heading, result.unwrapped_heading);
                    failures++;
                end
                if (result.motion_ok !== e.motion_ok)
                begin
                    $display("%0t: motion_ok exp %0b got %0b", $time, e.motion_ok,
                             result.motion_ok);
                    failures++;
                end
                if (result.yaw_ok !== e.yaw_ok)
                begin
                    $display("%0t: yaw_ok exp %0b got %0b", $time, e.yaw_ok, result.yaw_ok);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        swap_q = 1'b0;
        gain_x_q = GAIN_X_RESET;
        gain_y_q = GAIN_Y_RESET;
        last_yaw_q = '0;
        smooth_x_q = '0;
        smooth_y_q = '0;
        acc_x_q = '0;
        acc_y_q = '0;
        turns_q = '0;
        cfg.valid = 1'b0;
        cfg.reg_index = REG_SWAP_AXES;
        cfg.data = '0;
        sample.valid = 1'b0;
        sample.operation = OP_SAMPLE;
        sample.count_x = '0;
        sample.count_y = '0;
        sample.yaw_sample = '0;
        sample.load_x = '0;
        sample.load_y = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_default_gains();
        test_swapped_extreme_gains();
        test_inverted_extreme_gains();
        test_zero_gain();
        test_random_gains();
        settle();
        if (failures == 0)
            $display("[planar_odometry_integrator] OK");
        else
            $display("[planar_odometry_integrator] ERROR");
        $finish;
    end

endmodule
